FILE: hdl/bsdt_pkg.sv
// ----------------------------------------------------------------------------
// bsdt_pkg
// Shared types and constants for the block stack delta tracker.
// ----------------------------------------------------------------------------
package bsdt_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned ALL_SLOTS_SHIFT = 3;

  localparam logic [SLOT_W-1:0] SLOT_RESET   = 4'd8;
  localparam logic [DATA_W-1:0] UNKNOWN_MARK = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_OTHER = 4'd0,
    OP_PUSH  = 4'd1,
    OP_POP   = 4'd2,
    OP_PUSHA = 4'd3,
    OP_POPA  = 4'd4,
    OP_ADD   = 4'd5,
    OP_SUB   = 4'd6,
    OP_MOV   = 4'd7,
    OP_LEAVE = 4'd8,
    OP_LEA   = 4'd9,
    OP_CALL  = 4'd10,
    OP_RET   = 4'd11
  } op_class_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_REG  = 2'd1,
    SRC_IMM  = 2'd2,
    SRC_MEM  = 2'd3
  } src_kind_t;

  typedef struct packed {
    logic [3:0]               op_class;
    logic                     defines_sp;
    logic [1:0]               src_kind;
    logic                     src_base_is_sp;
    logic                     src_base_is_bp;
    logic                     src_has_index;
    logic                     dest_is_bp_reg;
    logic signed [DATA_W-1:0] immediate;
    logic                     opaque_block;
    logic                     no_instruction;
    logic                     last_in_block;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sp_delta;
    logic                     delta_unknown;
    logic                     sets_frame_pointer;
    logic signed [DATA_W-1:0] frame_pointer_offset;
    logic                     resets_to_frame_pointer;
  } result_t;

endpackage

FILE: hdl/bsdt_in_stage.sv
// ----------------------------------------------------------------------------
// bsdt_in_stage
// Input register: holds one decoded instruction until the tracker takes it.
// ----------------------------------------------------------------------------
module bsdt_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bsdt_pkg::item_t in_item,
  input  logic           take,
  output logic           s1_valid,
  output bsdt_pkg::item_t s1_item
);

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  bsdt_pkg::item_t s1_item_r;

  assign in_stall = s1_valid_r && !take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

FILE: hdl/bsdt_track.sv
// ----------------------------------------------------------------------------
// bsdt_track
// Per-block state and the single-pass delta update for one instruction.
// ----------------------------------------------------------------------------
module bsdt_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bsdt_pkg::SLOT_W-1:0]   cfg_wr_data,
  input  bsdt_pkg::item_t               s1_item,
  input  logic                          take,
  output bsdt_pkg::result_t             res
);

  logic [bsdt_pkg::SLOT_W-1:0] slot_bytes_r;
  logic [bsdt_pkg::DATA_W-1:0] delta_r, delta_nxt;
  logic                        unk_r, unk_nxt;
  logic                        fps_r, fps_nxt;
  logic [bsdt_pkg::DATA_W-1:0] fpo_r, fpo_nxt;
  logic                        fpr_r, fpr_nxt;
  logic                        opq_r, opq_nxt;

  logic [bsdt_pkg::DATA_W-1:0] d_upd;
  logic                        u_upd;
  logic                        fps_upd;
  logic [bsdt_pkg::DATA_W-1:0] fpo_upd;
  logic                        fpr_upd;
  logic                        opq;
  logic [bsdt_pkg::DATA_W-1:0] slot;
  logic [bsdt_pkg::DATA_W-1:0] imm;
  bsdt_pkg::op_class_t         cls;
  bsdt_pkg::src_kind_t         skind;
  logic                        recovers;

  always_comb begin
    cls      = bsdt_pkg::op_class_t'(s1_item.op_class);
    skind    = bsdt_pkg::src_kind_t'(s1_item.src_kind);
    slot     = {{(bsdt_pkg::DATA_W-bsdt_pkg::SLOT_W){1'b0}}, slot_bytes_r};
    imm      = $unsigned(s1_item.immediate);
    opq      = opq_r | s1_item.opaque_block;
    recovers = (cls == bsdt_pkg::OP_MOV) || (cls == bsdt_pkg::OP_LEAVE) ||
               (cls == bsdt_pkg::OP_LEA);
    d_upd    = delta_r;
    u_upd    = unk_r;
    fps_upd  = fps_r;
    fpo_upd  = fpo_r;
    fpr_upd  = fpr_r;
    if (!s1_item.no_instruction && !opq) begin
      if (cls == bsdt_pkg::OP_MOV && s1_item.dest_is_bp_reg &&
          skind == bsdt_pkg::SRC_REG && s1_item.src_base_is_sp) begin
        fps_upd = 1'b1;
        fpo_upd = delta_r;
      end
      if (s1_item.defines_sp && (!unk_r || recovers)) begin
        unique case (cls)
          bsdt_pkg::OP_PUSH:  d_upd = delta_r + slot;
          bsdt_pkg::OP_POP:   d_upd = delta_r - slot;
          bsdt_pkg::OP_PUSHA: d_upd = delta_r + (slot << bsdt_pkg::ALL_SLOTS_SHIFT);
          bsdt_pkg::OP_POPA:  d_upd = delta_r - (slot << bsdt_pkg::ALL_SLOTS_SHIFT);
          bsdt_pkg::OP_ADD: begin
            if (skind == bsdt_pkg::SRC_IMM) begin
              d_upd = delta_r - imm;
            end else begin
              u_upd = 1'b1;
              d_upd = bsdt_pkg::UNKNOWN_MARK;
            end
          end
          bsdt_pkg::OP_SUB: begin
            if (skind == bsdt_pkg::SRC_IMM) begin
              d_upd = delta_r + imm;
            end else begin
              u_upd = 1'b1;
              d_upd = bsdt_pkg::UNKNOWN_MARK;
            end
          end
          bsdt_pkg::OP_MOV: begin
            if (skind == bsdt_pkg::SRC_REG && s1_item.src_base_is_bp) begin
              fpr_upd = 1'b1;
            end
            u_upd = 1'b0;
            d_upd = '0;
          end
          bsdt_pkg::OP_LEAVE: begin
            fpr_upd = 1'b1;
            u_upd   = 1'b0;
            d_upd   = '0 - slot;
          end
          bsdt_pkg::OP_LEA: begin
            if (s1_item.src_base_is_bp && !s1_item.src_has_index) begin
              fpr_upd = 1'b1;
              u_upd   = 1'b0;
              d_upd   = '0 - imm;
            end else begin
              u_upd = 1'b1;
              d_upd = bsdt_pkg::UNKNOWN_MARK;
            end
          end
          bsdt_pkg::OP_CALL: d_upd = delta_r;
          bsdt_pkg::OP_RET: begin
            if (skind == bsdt_pkg::SRC_IMM) begin
              d_upd = delta_r - imm;
            end
          end
          default: begin
            u_upd = 1'b1;
            d_upd = bsdt_pkg::UNKNOWN_MARK;
          end
        endcase
      end
    end

    if (opq) begin
      res = '0;
    end else begin
      res.sp_delta                = $signed(d_upd);
      res.delta_unknown           = u_upd;
      res.sets_frame_pointer      = fps_upd;
      res.frame_pointer_offset    = fps_upd ? $signed(fpo_upd) : '0;
      res.resets_to_frame_pointer = fpr_upd;
    end

    delta_nxt = d_upd;
    unk_nxt   = u_upd;
    fps_nxt   = fps_upd;
    fpo_nxt   = fpo_upd;
    fpr_nxt   = fpr_upd;
    opq_nxt   = opq;
    if (s1_item.last_in_block) begin
      delta_nxt = '0;
      unk_nxt   = 1'b0;
      fps_nxt   = 1'b0;
      fpo_nxt   = '0;
      fpr_nxt   = 1'b0;
      opq_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes_r <= bsdt_pkg::SLOT_RESET;
    end else if (cfg_wr_en) begin
      slot_bytes_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= '0;
      unk_r   <= 1'b0;
      fps_r   <= 1'b0;
      fpo_r   <= '0;
      fpr_r   <= 1'b0;
      opq_r   <= 1'b0;
    end else if (take) begin
      delta_r <= delta_nxt;
      unk_r   <= unk_nxt;
      fps_r   <= fps_nxt;
      fpo_r   <= fpo_nxt;
      fpr_r   <= fpr_nxt;
      opq_r   <= opq_nxt;
    end
  end

  a_unknown_mark: assert property (@(posedge clk) disable iff (!rst_n)
    unk_r |-> (delta_r == bsdt_pkg::UNKNOWN_MARK))
    else $error("unknown delta without sentinel value");

  a_fp_offset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !fps_r |-> (fpo_r == '0))
    else $error("frame pointer offset set without flag");

  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_item.last_in_block) |=>
      (delta_r == '0 && !unk_r && !fps_r && !fpr_r && !opq_r))
    else $error("block state not cleared after last item");

endmodule

FILE: hdl/bsdt_out_stage.sv
// ----------------------------------------------------------------------------
// bsdt_out_stage
// Result register: holds one block result until the consumer takes it.
// ----------------------------------------------------------------------------
module bsdt_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bsdt_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output bsdt_pkg::result_t out_res
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  bsdt_pkg::result_t out_res_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: hdl/block_stack_delta_tracker.sv
// ----------------------------------------------------------------------------
// block_stack_delta_tracker
// Running stack pointer delta per basic block, one instruction per item.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register until the tracker
//   takes it, which updates block state and loads a closing item's result
//   into the out_ register. Throughput: one item per cycle while no stall
//   holds the flow; a closing item waits while the out_ register is full and stalled.
// Reset: synchronous, active low; clears block state and both stage valids,
//   and loads a slot size of 8 bytes.
module block_stack_delta_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_op_class,
  input  logic               in_defines_sp,
  input  logic [1:0]         in_src_kind,
  input  logic               in_src_base_is_sp,
  input  logic               in_src_base_is_bp,
  input  logic               in_src_has_index,
  input  logic               in_dest_is_bp_reg,
  input  logic signed [31:0] in_immediate,
  input  logic               in_opaque_block,
  input  logic               in_no_instruction,
  input  logic               in_last_in_block,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sp_delta,
  output logic               out_delta_unknown,
  output logic               out_sets_frame_pointer,
  output logic signed [31:0] out_frame_pointer_offset,
  output logic               out_resets_to_frame_pointer
);

  bsdt_pkg::item_t   in_item;
  bsdt_pkg::item_t   s1_item;
  bsdt_pkg::result_t res;
  bsdt_pkg::result_t out_res;
  logic              s1_valid;
  logic              out_free;
  logic              take;

  always_comb begin
    in_item.op_class       = in_op_class;
    in_item.defines_sp     = in_defines_sp;
    in_item.src_kind       = in_src_kind;
    in_item.src_base_is_sp = in_src_base_is_sp;
    in_item.src_base_is_bp = in_src_base_is_bp;
    in_item.src_has_index  = in_src_has_index;
    in_item.dest_is_bp_reg = in_dest_is_bp_reg;
    in_item.immediate      = in_immediate;
    in_item.opaque_block   = in_opaque_block;
    in_item.no_instruction = in_no_instruction;
    in_item.last_in_block  = in_last_in_block;
  end

  assign take = s1_valid && (!s1_item.last_in_block || out_free);

  bsdt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  bsdt_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s1_item     (s1_item),
    .take        (take),
    .res         (res)
  );

  bsdt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && s1_item.last_in_block),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_sp_delta                = out_res.sp_delta;
  assign out_delta_unknown           = out_res.delta_unknown;
  assign out_sets_frame_pointer      = out_res.sets_frame_pointer;
  assign out_frame_pointer_offset    = out_res.frame_pointer_offset;
  assign out_resets_to_frame_pointer = out_res.resets_to_frame_pointer;

endmodule
